### hdl/svts_pkg.sv
// Package for the SQL VALUES tuple splitter: byte constants, error codes
// and the request and response item structs. No dependencies.
package svts_pkg;

   localparam logic [7:0] CHAR_SEMI      = 8'h3B;  // ;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;  // (
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;  // ,
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;  // )
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;  // '
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;  // backslash
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;  // LF

   localparam int unsigned ERR_W = 3;
   localparam int unsigned IDX_W = 6;

   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NO_LPAREN = 3'd1;
   localparam logic [ERR_W-1:0] ERR_NO_QUOTE  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_NO_RPAREN = 3'd3;
   localparam logic [ERR_W-1:0] ERR_BAD_END   = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       line_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0]       echo_byte;
      logic             in_tuple_text;
      logic             field_byte;
      logic             field_end;
      logic             tuple_end;
      logic [IDX_W-1:0] field_index;
      logic             statement_done;
      logic [ERR_W-1:0] error_code;
   } rsp_item_type;

endpackage

### hdl/sql_values_tuple_splitter_top.sv
// SQL VALUES tuple splitter: tags each byte of a dump line after VALUES.
// The response is registered: rsp_valid rises in the cycle after accept.
// Throughput: one item per cycle unless rsp_ready holds the response; the
// parse update and tagging are combinational, and the response register reloads in the cycle it is taken.
// Reset (synchronous, active high): parser expects a tuple start, field
// counter cleared, no response pending.
module sql_values_tuple_splitter_top #(
   parameter int unsigned MAX_FIELD_INDEX = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  svts_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output svts_pkg::rsp_item_type rsp_data
);
   import svts_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_FIELD_INDEX + 1);
   localparam int unsigned EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELD_INDEX);

   typedef enum logic [2:0] {
      ST_EXPECT = 3'd0,
      ST_FIELD  = 3'd1,
      ST_QUOTE  = 3'd2,
      ST_ESC    = 3'd3,
      ST_AFTER  = 3'd4,
      ST_SEMI   = 3'd5,
      ST_SKIP   = 3'd6
   } parse_state_type;

   parse_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_data_ff, rsp_data_in;
   logic             accept;
   logic [7:0]       b;
   logic             last;
   logic [EXT_W-1:0] idx_ext;
   logic [CNT_W-1:0] cnt_bump;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign b        = req_data.data_byte;
   assign last     = req_data.line_last;
   assign idx_ext  = EXT_W'(cnt_ff);
   assign cnt_bump = (cnt_ff >= CNT_MAX) ? CNT_MAX : cnt_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rsp_data_in = '0;
      rsp_data_in.echo_byte = b;
      unique case (state_ff) inside
         ST_EXPECT, ST_AFTER: begin
            if (b == CHAR_LPAREN) begin
               rsp_data_in.in_tuple_text = 1'b1;
               cnt_in   = '0;
               state_in = ST_FIELD;
               if (last) rsp_data_in.error_code = ERR_NO_RPAREN;
            end else if (b == CHAR_SEMI) begin
               state_in = ST_SEMI;
               if (last) rsp_data_in.statement_done = 1'b1;
            end else if (b == CHAR_COMMA && state_ff == ST_AFTER) begin
               state_in = ST_EXPECT;
               if (last) rsp_data_in.error_code = ERR_NO_LPAREN;
            end else begin
               rsp_data_in.error_code = ERR_NO_LPAREN;
            end
         end
         ST_FIELD: begin
            rsp_data_in.in_tuple_text = 1'b1;
            rsp_data_in.field_index   = idx_ext[IDX_W-1:0];
            if (b == CHAR_COMMA) begin
               rsp_data_in.field_end = 1'b1;
               cnt_in = cnt_bump;
               if (last) rsp_data_in.error_code = ERR_NO_RPAREN;
            end else if (b == CHAR_RPAREN) begin
               rsp_data_in.field_end = 1'b1;
               rsp_data_in.tuple_end = 1'b1;
               state_in = ST_AFTER;
               if (last) rsp_data_in.error_code = ERR_NO_LPAREN;
            end else begin
               rsp_data_in.field_byte = 1'b1;
               if (b == CHAR_QUOTE) state_in = ST_QUOTE;
               if (last) rsp_data_in.error_code = ERR_NO_RPAREN;
            end
         end
         ST_QUOTE: begin
            rsp_data_in.in_tuple_text = 1'b1;
            rsp_data_in.field_byte    = 1'b1;
            rsp_data_in.field_index   = idx_ext[IDX_W-1:0];
            if (b == CHAR_QUOTE) begin
               state_in = ST_FIELD;
               if (last) rsp_data_in.error_code = ERR_NO_RPAREN;
            end else begin
               if (b == CHAR_BACKSLASH) state_in = ST_ESC;
               if (last) rsp_data_in.error_code = ERR_NO_QUOTE;
            end
         end
         ST_ESC: begin
            rsp_data_in.in_tuple_text = 1'b1;
            rsp_data_in.field_byte    = 1'b1;
            rsp_data_in.field_index   = idx_ext[IDX_W-1:0];
            state_in = ST_QUOTE;
            if (last) rsp_data_in.error_code = ERR_NO_QUOTE;
         end
         ST_SEMI: begin
            if (b == CHAR_NEWLINE && last) rsp_data_in.statement_done = 1'b1;
            else rsp_data_in.error_code = ERR_BAD_END;
         end
         default: begin
            // skipping after an error (and the unused code): tags stay clear
         end
      endcase
      if (rsp_data_in.error_code != ERR_NONE) state_in = ST_SKIP;
      if (last) begin
         state_in = ST_EXPECT;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXPECT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff    <= state_in;
            cnt_ff      <= cnt_in;
            rsp_data_ff <= rsp_data_in;
         end
         if (req_ready) rsp_valid_ff <= req_valid;
      end
   end

   // a line end always returns the parser to its start state
   a_line_end_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.line_last |=> state_ff == ST_EXPECT && cnt_ff == '0)
      else $error("parser not back at tuple start after line end");

   a_cnt_saturates: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("field counter beyond its limit");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.statement_done |->
         rsp_data_ff.error_code == ERR_NONE && !rsp_data_ff.in_tuple_text)
      else $error("statement_done with error or tuple tag");

   a_tuple_end_tags: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff == ST_FIELD && req_data.data_byte == CHAR_RPAREN
         && !req_data.line_last |=> state_ff == ST_AFTER && rsp_data_ff.tuple_end)
      else $error("closing parenthesis not handled as tuple end");

endmodule

### tb/sv/tb_top.sv
// Testbench for sql_values_tuple_splitter_top: directed and random dump lines,
// every tagged byte checked against a behavioural parser kept in a scoreboard.
// Depends on svts_pkg and the splitter RTL.
module tb_top;
   import svts_pkg::*;

   localparam int unsigned FIELD_LIMIT = 63;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned ITEM_TARGET = 950;
   localparam int unsigned QUIET_FROM  = 850;

   typedef logic [7:0] byte_list_type[$];

   typedef enum logic [2:0] {
      PS_EXPECT, PS_FIELD, PS_QUOTE, PS_ESC, PS_AFTER, PS_SEMI, PS_SKIP
   } parse_state_type;

   class tag_scoreboard_type;
      rsp_item_type    tags_due[$];
      parse_state_type state;
      int unsigned     field_cnt;
      int unsigned     max_field;
      int unsigned     mismatches;

      function new(int unsigned max_field_index);
         max_field  = max_field_index;
         state      = PS_EXPECT;
         field_cnt  = 0;
         mismatches = 0;
      endfunction

      function void flag_error(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
      endfunction

      // work out the tags for one accepted byte and queue them
      function void note_byte(req_item_type req);
         rsp_item_type     t;
         logic [7:0]       b;
         logic             last;
         parse_state_type  nxt;
         logic [ERR_W-1:0] err;
         b = req.data_byte;
         last = req.line_last;
         t = '0;
         t.echo_byte = b;
         nxt = state;
         err = ERR_NONE;
         case (state) inside
            PS_EXPECT, PS_AFTER: begin
               if (b == CHAR_LPAREN) begin
                  t.in_tuple_text = 1'b1;
                  field_cnt = 0;
                  nxt = PS_FIELD;
                  if (last) err = ERR_NO_RPAREN;
               end else if (b == CHAR_SEMI) begin
                  nxt = PS_SEMI;
                  if (last) t.statement_done = 1'b1;
               end else if (b == CHAR_COMMA && state == PS_AFTER) begin
                  nxt = PS_EXPECT;
                  if (last) err = ERR_NO_LPAREN;
               end else begin
                  err = ERR_NO_LPAREN;
               end
            end
            PS_FIELD: begin
               t.in_tuple_text = 1'b1;
               t.field_index = field_cnt[IDX_W-1:0];
               if (b == CHAR_COMMA) begin
                  t.field_end = 1'b1;
                  field_cnt = (field_cnt >= max_field) ? max_field : field_cnt + 1;
                  if (last) err = ERR_NO_RPAREN;
               end else if (b == CHAR_RPAREN) begin
                  t.field_end = 1'b1;
                  t.tuple_end = 1'b1;
                  nxt = PS_AFTER;
                  if (last) err = ERR_NO_LPAREN;
               end else begin
                  t.field_byte = 1'b1;
                  if (b == CHAR_QUOTE) nxt = PS_QUOTE;
                  if (last) err = ERR_NO_RPAREN;
               end
            end
            PS_QUOTE: begin
               t.in_tuple_text = 1'b1;
               t.field_byte = 1'b1;
               t.field_index = field_cnt[IDX_W-1:0];
               if (b == CHAR_QUOTE) begin
                  nxt = PS_FIELD;
                  if (last) err = ERR_NO_RPAREN;
               end else begin
                  if (b == CHAR_BACKSLASH) nxt = PS_ESC;
                  if (last) err = ERR_NO_QUOTE;
               end
            end
            PS_ESC: begin
               t.in_tuple_text = 1'b1;
               t.field_byte = 1'b1;
               t.field_index = field_cnt[IDX_W-1:0];
               nxt = PS_QUOTE;
               if (last) err = ERR_NO_QUOTE;
            end
            PS_SEMI: begin
               if (b == CHAR_NEWLINE && last) t.statement_done = 1'b1;
               else err = ERR_BAD_END;
            end
            default: ;
         endcase
         t.error_code = err;
         if (err != ERR_NONE) nxt = PS_SKIP;
         if (last) begin
            nxt = PS_EXPECT;
            field_cnt = 0;
         end
         state = nxt;
         tags_due.push_back(t);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) flag_error($sformatf("%s expected %0d got %0d", name, want, got));
      endfunction

      function void check_tags(rsp_item_type got);
         rsp_item_type want;
         if (tags_due.size() == 0) begin
            flag_error($sformatf("item with nothing pending: %h", got));
            return;
         end
         want = tags_due.pop_front();
         compare_field("echo_byte", want.echo_byte, got.echo_byte);
         compare_field("in_tuple_text", want.in_tuple_text, got.in_tuple_text);
         compare_field("field_byte", want.field_byte, got.field_byte);
         compare_field("field_end", want.field_end, got.field_end);
         compare_field("tuple_end", want.tuple_end, got.tuple_end);
         compare_field("field_index", want.field_index, got.field_index);
         compare_field("statement_done", want.statement_done, got.statement_done);
         compare_field("error_code", want.error_code, got.error_code);
      endfunction

      function void close_out();
         if (tags_due.size() != 0)
            flag_error($sformatf("%0d items never arrived", tags_due.size()));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b1;
   rsp_item_type rsp_data;

   int unsigned  cycle_count = 0;
   int unsigned  idle_odds = 4;
   int unsigned  stall_odds = 8;
   int unsigned  stall_left = 0;
   bit           quiet = 1'b0;

   tag_scoreboard_type board = new(FIELD_LIMIT);

   sql_values_tuple_splitter_top #(.MAX_FIELD_INDEX(FIELD_LIMIT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_byte(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_tags(rsp_data);
   end

   // receiver back-pressure in bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left <= $urandom_range(1, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, line_last: last};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_line(input byte_list_type bytes);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.tags_due.size() != 0);
   endtask

   function automatic void put_str(ref byte_list_type q, input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic void put_field(ref byte_list_type q);
      logic [7:0] b;
      case ($urandom_range(0, 5))
         0: ;
         1: repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(48, 57)));
         2: begin
            q.push_back(CHAR_QUOTE);
            repeat ($urandom_range(0, 8)) begin
               if ($urandom_range(0, 9) == 0) begin
                  q.push_back(CHAR_BACKSLASH);
                  q.push_back(8'($urandom_range(0, 255)));
               end else begin
                  b = 8'($urandom_range(0, 255));
                  if (b == CHAR_QUOTE || b == CHAR_BACKSLASH) b = "x";
                  q.push_back(b);
               end
            end
            q.push_back(CHAR_QUOTE);
         end
         3: put_str(q, "NULL");
         4: repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_COMMA || b == CHAR_RPAREN || b == CHAR_QUOTE) b = "-";
            q.push_back(b);
         end
         default: put_str(q, "'it''s'");
      endcase
   endfunction

   function automatic void put_tuple(ref byte_list_type q);
      int unsigned n;
      q.push_back(CHAR_LPAREN);
      if ($urandom_range(0, 29) == 0) begin
         // wide tuple of empty fields to push the index into saturation
         repeat ($urandom_range(60, 70)) q.push_back(CHAR_COMMA);
      end else begin
         n = $urandom_range(1, 5);
         for (int f = 0; f < n; f++) begin
            if (f != 0) q.push_back(CHAR_COMMA);
            put_field(q);
         end
      end
      q.push_back(CHAR_RPAREN);
   endfunction

   function automatic void build_line(ref byte_list_type q);
      int unsigned ntup;
      int unsigned pos;
      q = {};
      ntup = $urandom_range(1, 4);
      for (int t = 0; t < ntup; t++) begin
         if (t != 0 && $urandom_range(0, 3) != 0) q.push_back(CHAR_COMMA);
         put_tuple(q);
      end
      case ($urandom_range(0, 9)) inside
         [0:4]: begin
            q.push_back(CHAR_SEMI);
            if ($urandom_range(0, 1) == 1) q.push_back(CHAR_NEWLINE);
         end
         5: begin
            q.push_back(CHAR_SEMI);
            repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
         end
         6: if ($urandom_range(0, 1) == 1) q.push_back(CHAR_COMMA);
         7: begin
            pos = $urandom_range(0, q.size() - 1);
            while (q.size() > pos + 1) void'(q.pop_back());
         end
         8: begin
            pos = $urandom_range(0, q.size() - 1);
            q.insert(pos, ($urandom_range(0, 1) == 1) ? CHAR_COMMA
                                                       : 8'($urandom_range(0, 255)));
            q.push_back(CHAR_SEMI);
         end
         default: begin
            q = {};
            repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   initial begin : stimulus
      byte_list_type line;
      int unsigned   sent;
      int unsigned   pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      line = {};
      put_str(line, "('a\\',b'),(1);\n");
      send_line(line);
      line = {};
      put_str(line, "('");
      line.push_back(8'h00);
      line.push_back(8'hFF);
      send_line(line);
      line = {};
      put_str(line, ";");
      send_line(line);
      line = {};
      put_str(line, "(");
      send_line(line);
      line = {};
      put_str(line, ")x");
      send_line(line);
      line = {};
      put_str(line, ";;");
      send_line(line);
      line = {};
      put_str(line, "('\\");
      send_line(line);

      wait_drained();

      sent = 0;
      while (sent < ITEM_TARGET) begin
         if ($urandom_range(0, 5) == 0) begin
            pick = $urandom_range(0, 3);
            idle_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : (pick == 2) ? 8 : 20;
            pick = $urandom_range(0, 3);
            stall_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : (pick == 2) ? 8 : 20;
         end
         if (sent >= QUIET_FROM) quiet = 1'b1;
         build_line(line);
         send_line(line);
         sent += line.size();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      board.close_out();
      if (board.mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
